[hw/rtl/buddy_slot_allocator_defines.svh]
// Assertion macros used by the buddy slot allocator RTL
`ifndef BUDDY_SLOT_ALLOCATOR_DEFINES_SVH
`define BUDDY_SLOT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define BSA_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("buddy slot allocator: property failed");
// Condition must never be true outside reset
`define BSA_ASSERT_NEVER(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("buddy slot allocator: forbidden condition seen");
`else
`define BSA_ASSERT(name, prop)
`define BSA_ASSERT_NEVER(name, cond)
`endif
`endif

[hw/rtl/bsa_pkg.sv]
// Package: sizes, codes, types and helper functions of the buddy slot allocator
package bsa_pkg;

	// Pool geometry
	localparam int POOL_SLOTS      = 128;
	localparam int MAX_BLOCK_SLOTS = 4;
	localparam int SLOT_W          = $clog2(POOL_SLOTS);
	localparam int GROUP_LG        = $clog2(MAX_BLOCK_SLOTS);
	localparam int GROUP_SLOTS     = 1 << GROUP_LG;
	localparam int NUM_GROUPS      = POOL_SLOTS / GROUP_SLOTS;
	localparam int GRP_W           = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int OFF_W           = (GROUP_LG > 0) ? GROUP_LG : 1;
	localparam int LG_W            = (GROUP_LG >= 2) ? 2 : 1;
	localparam int CNT_W           = GROUP_LG + 1;

	// Field widths
	localparam int CMD_W    = 1;
	localparam int BYTES_W  = 6;
	localparam int IDX_W    = 7;
	localparam int STATUS_W = 3;
	localparam int NSLOT_W  = 3;
	localparam int CFG_W    = 6;

	// Size limit
	localparam int LIMIT_CAP   = MAX_BLOCK_SLOTS * 8;
	localparam int CAP_BITS    = $clog2(LIMIT_CAP + 1);
	localparam int CAP_W       = (CFG_W > CAP_BITS) ? CFG_W : CAP_BITS;
	localparam int CFG_RESET   = 32;

	// Commands
	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ZERO    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_LARGE   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOSTART = 3'd4;

	// Result of checking one aligned group of slots
	typedef struct packed {
		logic             hit;
		logic [OFF_W-1:0] off;
	} scan_res_t;

	// Control of the block size store
	typedef struct packed {
		logic              wr_en;
		logic [SLOT_W-1:0] wr_addr;
		logic [LG_W-1:0]   wr_lg;
		logic              clr_en;
		logic [SLOT_W-1:0] clr_addr;
		logic [SLOT_W-1:0] rd_addr;
	} store_ctl_t;

	// Byte count to log2 of the slot count (power of two, at least one slot)
	function automatic logic [LG_W-1:0] size_to_lg(input logic [BYTES_W-1:0] bytes);
		logic [BYTES_W:0] need;
		logic [LG_W-1:0]  lg;
		need = ((BYTES_W+1)'(bytes) + (BYTES_W+1)'(7)) >> 3;
		lg   = '0;
		for (int i = 0; i < GROUP_LG; i++) begin
			if (need > (BYTES_W+1)'(1 << i)) begin
				lg = LG_W'(i + 1);
			end
		end
		return lg;
	endfunction

	// Log2 slot count to slot count
	function automatic logic [CNT_W-1:0] lg_to_slots(input logic [LG_W-1:0] lg);
		return CNT_W'(1) << lg;
	endfunction

endpackage

[hw/rtl/bsa_group_check.sv]
// Shared scan unit: finds the lowest free aligned block inside one slot group
module bsa_group_check import bsa_pkg::*; (
	input  logic [GROUP_SLOTS-1:0] grp_bits,
	input  logic [LG_W-1:0]        lg,
	output scan_res_t              res
);

	logic [GROUP_SLOTS:0]   span_ext;
	logic [GROUP_SLOTS-1:0] span;

	// Test every aligned candidate, keep the lowest free one
	always_comb begin
		span_ext = ((GROUP_SLOTS+1)'(1) << (1 << lg)) - (GROUP_SLOTS+1)'(1);
		span     = span_ext[GROUP_SLOTS-1:0];
		res      = '0;
		for (int p = GROUP_SLOTS - 1; p >= 0; p--) begin
			if (((p & ((1 << lg) - 1)) == 0) && (((grp_bits >> p) & span) == '0)) begin
				res.hit = 1'b1;
				res.off = OFF_W'(p);
			end
		end
	end

endmodule

[hw/rtl/bsa_size_store.sv]
// Block size store: size code per start slot, with a valid bit per entry
module bsa_size_store import bsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  store_ctl_t        ctl,
	output logic [LG_W-1:0]   rd_lg,
	output logic              rd_addr_valid
);

	logic [LG_W-1:0]       mem [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] valid_q;
	logic [LG_W-1:0]       rd_lg_q;

	// Mark entries that hold a block start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ctl.clr_en) begin
				valid_q[ctl.clr_addr] <= 1'b0;
			end
			if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
		end
	end

	// Write and registered read of the size codes
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= ctl.wr_lg;
		end
		rd_lg_q <= mem[ctl.rd_addr];
	end

	assign rd_lg         = rd_lg_q;
	assign rd_addr_valid = valid_q[ctl.rd_addr];

endmodule

[hw/rtl/buddy_slot_allocator.sv]
// Top level: buddy slot allocator over a pool of eight-byte slots
//
//   channel   signals                                   transfer when
//   request   start, busy, command, size_bytes,         start && !busy
//             slot_index
//   config    cfg_valid, cfg_ready, cfg_data            cfg_valid && cfg_ready
//   result    done, status, granted_slot, block_slots   done (one cycle)
//
// Rejected requests answer in the cycle after the transfer; a free answers after passing through the release state.
// An allocate scans one aligned group of GROUP_SLOTS slots per cycle through the
// shared group check unit until it finds a hit or has checked the last group.
// busy is low in the cycle that done is shown, so the next request may follow.
// Reset clears the pool and the valid bits of the size store at once; no clearing pass.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "buddy_slot_allocator_defines.svh"
module buddy_slot_allocator import bsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [BYTES_W-1:0]  size_bytes,
	input  logic [IDX_W-1:0]    slot_index,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [IDX_W-1:0]    granted_slot,
	output logic [NSLOT_W-1:0]  block_slots
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FREE = 3'b100
	} state_t;

	state_t                state_q;
	logic [GRP_W-1:0]      grp_q;
	logic [LG_W-1:0]       lg_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [POOL_SLOTS-1:0] slot_used_q;
	logic [CFG_W-1:0]      limit_q;
	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [IDX_W-1:0]      granted_q;
	logic [NSLOT_W-1:0]    nslot_q;

	logic [CAP_W-1:0]      limit_eff;
	logic                  too_large;
	logic                  idx_out_of_pool;
	logic [SLOT_W-1:0]     base_slot;
	logic [SLOT_W-1:0]     hit_slot;
	logic [GROUP_SLOTS-1:0] grp_bits;
	scan_res_t             scan_res;
	store_ctl_t            store_ctl;
	logic [LG_W-1:0]       rd_lg;
	logic                  rd_addr_valid;
	logic [POOL_SLOTS-1:0] alloc_mask;
	logic [POOL_SLOTS-1:0] free_mask;
	logic                  accept;

	assign accept = start && !busy;

	// Size limit in force and request checks
	always_comb begin
		limit_eff = (CAP_W'(limit_q) > CAP_W'(LIMIT_CAP)) ? CAP_W'(LIMIT_CAP) : CAP_W'(limit_q);
		too_large = CAP_W'(size_bytes) > limit_eff;
		idx_out_of_pool = (SLOT_W+IDX_W)'(slot_index) >= (SLOT_W+IDX_W)'(POOL_SLOTS);
	end

	// Select the group under scan
	assign base_slot = SLOT_W'(grp_q) << GROUP_LG;
	assign grp_bits  = slot_used_q[base_slot +: GROUP_SLOTS];
	assign hit_slot  = base_slot | SLOT_W'(scan_res.off);

	bsa_group_check u_check (
		.grp_bits (grp_bits),
		.lg       (lg_q),
		.res      (scan_res)
	);

	// Slot masks for grant and release
	always_comb begin
		alloc_mask = ((POOL_SLOTS'(1) << lg_to_slots(lg_q)) - POOL_SLOTS'(1)) << hit_slot;
		free_mask  = ((POOL_SLOTS'(1) << lg_to_slots(rd_lg)) - POOL_SLOTS'(1)) << idx_q;
	end

	// Drive the size store
	always_comb begin
		store_ctl.wr_en    = (state_q == S_SCAN) && scan_res.hit;
		store_ctl.wr_addr  = hit_slot;
		store_ctl.wr_lg    = lg_q;
		store_ctl.clr_en   = (state_q == S_FREE);
		store_ctl.clr_addr = idx_q;
		store_ctl.rd_addr  = SLOT_W'(slot_index);
	end

	bsa_size_store u_store (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (store_ctl),
		.rd_lg         (rd_lg),
		.rd_addr_valid (rd_addr_valid)
	);

	// Hold the size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CFG_W'(CFG_RESET);
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Sequencer: decode, scan groups, release blocks, post one result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			grp_q       <= '0;
			lg_q        <= '0;
			idx_q       <= '0;
			slot_used_q <= '0;
			done_q      <= 1'b0;
			status_q    <= STAT_OK;
			granted_q   <= '0;
			nslot_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						granted_q <= '0;
						nslot_q   <= '0;
						if (command == CMD_ALLOC) begin
							if (size_bytes == '0) begin
								done_q   <= 1'b1;
								status_q <= STAT_ZERO;
							end else if (too_large) begin
								done_q   <= 1'b1;
								status_q <= STAT_LARGE;
							end else begin
								lg_q    <= size_to_lg(size_bytes);
								grp_q   <= '0;
								state_q <= S_SCAN;
							end
						end else begin
							if (idx_out_of_pool || !rd_addr_valid) begin
								done_q   <= 1'b1;
								status_q <= STAT_NOSTART;
							end else begin
								idx_q   <= SLOT_W'(slot_index);
								state_q <= S_FREE;
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_res.hit) begin
						slot_used_q <= slot_used_q | alloc_mask;
						done_q      <= 1'b1;
						status_q    <= STAT_OK;
						granted_q   <= IDX_W'(hit_slot);
						nslot_q     <= NSLOT_W'(lg_to_slots(lg_q));
						state_q     <= S_IDLE;
					end else if (grp_q == GRP_W'(NUM_GROUPS - 1)) begin
						done_q   <= 1'b1;
						status_q <= STAT_FULL;
						state_q  <= S_IDLE;
					end else begin
						grp_q <= grp_q + GRP_W'(1);
					end
				end
				S_FREE: begin
					slot_used_q <= slot_used_q & ~free_mask;
					done_q      <= 1'b1;
					status_q    <= STAT_OK;
					granted_q   <= IDX_W'(idx_q);
					nslot_q     <= NSLOT_W'(lg_to_slots(rd_lg));
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign done         = done_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign block_slots  = nslot_q;

	// A result only follows an accepted request or a working state
	`BSA_ASSERT(a_done_has_cause, done |-> ($past(start) || $past(state_q != S_IDLE)))
	// A failed request reports no slot and no size
	`BSA_ASSERT_NEVER(a_fail_is_clean, done && (status != STAT_OK) && ((granted_slot != '0) || (block_slots != '0)))
	// A hit in the scan is reported as a grant in the next cycle
	`BSA_ASSERT(a_hit_grants, ((state_q == S_SCAN) && scan_res.hit) |=> (done && (status == STAT_OK)))

endmodule

[bench/bsa_checker.sv]
// Checker for the buddy slot allocator: follows the channels, predicts replies, compares
`timescale 1ns / 100ps
module bsa_checker import bsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [BYTES_W-1:0]  size_bytes,
	input  logic [IDX_W-1:0]    slot_index,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                done,
	input  logic [STATUS_W-1:0] status,
	input  logic [IDX_W-1:0]    granted_slot,
	input  logic [NSLOT_W-1:0]  block_slots,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] stat;
		logic [IDX_W-1:0]    slot;
		logic [NSLOT_W-1:0]  nslots;
	} reply_t;

	// Shadow copy of the pool and the size register
	bit               pool_used [POOL_SLOTS];
	int               block_len_at [POOL_SLOTS];
	int               limit_bytes;
	reply_t           reply_q [$];
	int               mismatch_cnt;

	// Work out the reply to one request and update the shadow pool
	task automatic compute_reply(input logic [CMD_W-1:0] cmd, input logic [BYTES_W-1:0] bytes,
			input logic [IDX_W-1:0] idx, output reply_t r);
		int lim;
		int need;
		int n;
		int base;
		int k;
		bit hit;
		r = '{STAT_OK, '0, '0};
		if (cmd == CMD_ALLOC) begin
			lim = (limit_bytes > LIMIT_CAP) ? LIMIT_CAP : limit_bytes;
			if (bytes == 0) begin
				r.stat = STAT_ZERO;
			end else if (int'(bytes) > lim) begin
				r.stat = STAT_LARGE;
			end else begin
				// exact multiples of eight take no extra step up
				need = (int'(bytes) + 7) / 8;
				n = 1;
				while (n < need) n = n << 1;
				r.stat = STAT_FULL;
				hit = 1'b0;
				// lowest aligned block with every slot unused
				for (base = 0; base + n <= POOL_SLOTS && !hit; base += n) begin
					hit = 1'b1;
					for (k = 0; k < n; k++) if (pool_used[base + k]) hit = 1'b0;
					if (hit) begin
						for (k = 0; k < n; k++) pool_used[base + k] = 1'b1;
						block_len_at[base] = n;
						r = '{STAT_OK, IDX_W'(base), NSLOT_W'(n)};
					end
				end
			end
		end else begin
			if (int'(idx) >= POOL_SLOTS || block_len_at[idx] == 0) begin
				r.stat = STAT_NOSTART;
			end else begin
				n = block_len_at[idx];
				for (k = 0; k < n && int'(idx) + k < POOL_SLOTS; k++) pool_used[idx + k] = 1'b0;
				block_len_at[idx] = 0;
				r = '{STAT_OK, idx, NSLOT_W'(n)};
			end
		end
	endtask

	// Compare replies, then take in config and request transfers
	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			for (int i = 0; i < POOL_SLOTS; i++) begin
				pool_used[i] = 1'b0;
				block_len_at[i] = 0;
			end
			limit_bytes = CFG_RESET;
			reply_q.delete();
			mismatch_cnt = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (done) begin
				got = '{status, granted_slot, block_slots};
				if (reply_q.size() == 0) begin
					if (mismatch_cnt < 10)
						$display("unexpected reply at %0t: status %0d slot %0d slots %0d",
							$realtime, got.stat, got.slot, got.nslots);
					mismatch_cnt++;
				end else begin
					want = reply_q.pop_front();
					if (got.stat !== want.stat || got.slot !== want.slot
							|| got.nslots !== want.nslots) begin
						if (mismatch_cnt < 10)
							$display("mismatch at %0t: expected status %0d slot %0d slots %0d, got status %0d slot %0d slots %0d",
								$realtime, want.stat, want.slot, want.nslots,
								got.stat, got.slot, got.nslots);
						mismatch_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) limit_bytes = int'(cfg_data);
			if (start && !busy) begin
				compute_reply(command, size_bytes, slot_index, want);
				reply_q.push_back(want);
			end
			fail_count <= mismatch_cnt;
			pending <= reply_q.size();
		end
	end

endmodule

[bench/tb.sv]
// Testbench top for the buddy slot allocator: clock, reset, stimulus and verdict
`timescale 1ns / 100ps
module tb;
	import bsa_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 193;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [CMD_W-1:0]    command;
	logic [BYTES_W-1:0]  size_bytes;
	logic [IDX_W-1:0]    slot_index;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    granted_slot;
	logic [NSLOT_W-1:0]  block_slots;
	int                  fail_count;
	int                  pending;
	int                  cycles;

	// Commands awaiting a reply, and start slots of blocks believed live
	logic [CMD_W-1:0]    cmd_q [$];
	logic [IDX_W-1:0]    live_q [$];

	buddy_slot_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .size_bytes(size_bytes), .slot_index(slot_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .granted_slot(granted_slot),
		.block_slots(block_slots)
	);

	bsa_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .size_bytes(size_bytes), .slot_index(slot_index),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .status(status), .granted_slot(granted_slot),
		.block_slots(block_slots), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Track live blocks from the replies so that frees mostly hit real starts
	always @(posedge clk) begin : track
		logic [CMD_W-1:0] c;
		if (done && cmd_q.size() != 0) begin
			c = cmd_q.pop_front();
			if (status == STAT_OK) begin
				if (c == CMD_ALLOC) begin
					live_q.push_back(granted_slot);
				end else begin
					for (int i = 0; i < live_q.size(); i++) begin
						if (live_q[i] == granted_slot) begin
							live_q.delete(i);
							break;
						end
					end
				end
			end
		end
		if (start && !busy) cmd_q.push_back(command);
	end

	// Offer one request and hold it until the transfer
	task automatic send(input logic [CMD_W-1:0] c, input int b, input int idx);
		start      <= 1'b1;
		command    <= c;
		size_bytes <= BYTES_W'(b);
		slot_index <= IDX_W'(idx);
		do @(posedge clk); while (busy);
	endtask

	// Write the size limit register
	task automatic set_limit(input int v);
		cfg_valid <= 1'b1;
		cfg_data  <= CFG_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Wait until every reply has come back
	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic int pick_size(input int lim);
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 0;
		if (r < 20 || lim == 0) return $urandom_range(0, 63);
		return $urandom_range(1, (lim > LIMIT_CAP) ? LIMIT_CAP : lim);
	endfunction

	// Random requests in bursts with gaps; frees mostly aimed at live blocks
	task automatic run_random(input int count, input int lim);
		int sent;
		int burst;
		int alloc_pct;
		int idx;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			case ($urandom_range(0, 2))
				0: alloc_pct = 20;
				1: alloc_pct = 50;
				default: alloc_pct = 85;
			endcase
			for (int i = 0; i < burst && sent < count; i++) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					send(CMD_ALLOC, pick_size(lim), $urandom_range(0, 127));
				end else begin
					if (live_q.size() != 0 && $urandom_range(0, 3) != 0)
						idx = live_q[$urandom_range(0, live_q.size() - 1)];
					else
						idx = $urandom_range(0, 127);
					send(CMD_FREE, $urandom_range(0, 63), idx);
				end
				sent++;
				// hold off once mid-phase until the pipeline is empty
				if (sent == count / 2) begin
					start <= 1'b0;
					drain();
				end
			end
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 45)) @(posedge clk);
			end
		end
		start <= 1'b0;
	endtask

	initial begin : stim
		int limits [10];
		limits = '{63, 0, 1, 8, 9, 16, 17, 24, 31, 32};
		arst_n     <= 1'b0;
		start      <= 1'b0;
		command    <= CMD_ALLOC;
		size_bytes <= '0;
		slot_index <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: size edges, rounding of exact multiples, bad frees, reuse
		set_limit(32);
		send(CMD_ALLOC, 0, 0);
		send(CMD_ALLOC, 63, 0);
		send(CMD_ALLOC, 33, 0);
		send(CMD_ALLOC, 1, 127);
		send(CMD_ALLOC, 8, 0);
		send(CMD_ALLOC, 9, 0);
		send(CMD_ALLOC, 16, 0);
		send(CMD_ALLOC, 17, 0);
		send(CMD_ALLOC, 32, 0);
		send(CMD_FREE, 63, 3);
		send(CMD_FREE, 0, 127);
		send(CMD_FREE, 0, 0);
		send(CMD_ALLOC, 1, 0);
		send(CMD_FREE, 0, 2);
		send(CMD_ALLOC, 5, 0);
		send(CMD_FREE, 0, 8);
		send(CMD_FREE, 0, 8);
		start <= 1'b0;
		drain();

		// Random phases, one per limit setting
		foreach (limits[p]) begin
			set_limit(limits[p]);
			run_random(PHASE_ITEMS, limits[p]);
			drain();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
